FILE: src/bdc_pkg.sv
// ----------------------------------------------------------------------------
// bdc_pkg
// shared types and constants of the button debounce and click classifier
// ----------------------------------------------------------------------------
package bdc_pkg;

  localparam int BUTTONS              = 16;
  localparam int BTN_W                = 4;
  localparam int TIME_W               = 32;
  localparam int DEBOUNCE_RESET_COUNT = 5;
  localparam int MAX_PRESSES          = 3;
  localparam int MAX_EVENTS           = 4;
  localparam int IN_DATA_W            = 40;
  localparam int OUT_DATA_W           = 8;
  localparam int CFG_ADDR_W           = 5;

  typedef enum logic [2:0] {
    EV_PRESSED  = 3'd0,
    EV_RELEASED = 3'd1,
    EV_NORMAL   = 3'd2,
    EV_RELHOLD  = 3'd3,
    EV_DOUBLE   = 3'd4,
    EV_TRIPLE   = 3'd5,
    EV_LONG     = 3'd6
  } bdc_event_t;

  typedef enum logic [2:0] {
    REG_DEBOUNCE    = 3'd0,
    REG_LONG_THRESH = 3'd1,
    REG_MULTI_WIN   = 3'd2,
    REG_HOLD_MASK   = 3'd3,
    REG_DOUBLE_MASK = 3'd4,
    REG_TRIPLE_MASK = 3'd5,
    REG_LONG_MASK   = 3'd6
  } bdc_reg_t;

  localparam logic ACT_SAMPLE  = 1'b0;
  localparam logic ACT_SERVICE = 1'b1;

  typedef struct packed {
    logic              bounce_level;
    logic              stable_level;
    logic [7:0]        bounce_counter;
    logic              long_fired;
    logic [1:0]        press_count;
    logic              multi_pending;
    logic [TIME_W-1:0] press_time;
    logic [TIME_W-1:0] release_time;
  } bdc_entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [BTN_W-1:0] rd_addr;
    logic             wr_en;
    logic [BTN_W-1:0] wr_addr;
  } bdc_mem_req_t;

endpackage

FILE: src/button_debounce_click_classifier_unit.sv
// ----------------------------------------------------------------------------
// button_debounce_click_classifier_unit
// debounces raw button samples and classifies presses into click events
// ----------------------------------------------------------------------------
// An item is taken at the same edge at which the previous one leaves the state
// read stage; per-button state is read from a registered memory at accept,
// updated and written back as the item leaves the stage, with forwarding for
// back-to-back requests on one button. Events leave through a single output
// buffer at one per cycle while the output is ready; a release yields one
// event, a plain press two and a press that completes a double or triple
// three, and an item can leave as the last event of the previous one is taken.
// ----------------------------------------------------------------------------
module button_debounce_click_classifier_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: button[3:0], level[4], now_ms[36:5], zero fill
  input  logic [bdc_pkg::IN_DATA_W-1:0]    in_tdata,
  // in_tuser: action
  input  logic                             in_tuser,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // out_tdata: event_res[2:0], event_button[6:3], zero fill
  output logic [bdc_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [bdc_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);
  import bdc_pkg::*;

  logic [7:0]  debounce_r;
  logic [15:0] long_thresh_r;
  logic [15:0] multi_win_r;
  logic [15:0] hold_mask_r;
  logic [15:0] double_mask_r;
  logic [15:0] triple_mask_r;
  logic [15:0] long_mask_r;

  logic              b_vld_r;
  logic              b_action_r;
  logic [BTN_W-1:0]  b_button_r;
  logic              b_level_r;
  logic [TIME_W-1:0] b_now_r;

  bdc_event_t        ev_buf_r [MAX_EVENTS];
  logic [BTN_W-1:0]  ev_btn_r;
  logic [2:0]        rem_r;
  logic [1:0]        pos_r;

  bdc_mem_req_t      mem_req;
  bdc_entry_t        old_st;
  bdc_entry_t        new_st;
  bdc_event_t        ev [MAX_EVENTS];
  logic [2:0]        ev_n;

  logic              in_acc;
  logic              out_acc;
  logic              b_fire;
  logic              cfg_wr;
  logic [TIME_W-1:0] d_press;
  logic [TIME_W-1:0] d_rel;
  logic [TIME_W-1:0] mwin;
  logic [TIME_W-1:0] lthr;
  logic              dbl;
  logic              tpl;
  logic              hold;
  logic              lmask;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r    <= 8'(DEBOUNCE_RESET_COUNT);
      long_thresh_r <= '0;
      multi_win_r   <= '0;
      hold_mask_r   <= '0;
      double_mask_r <= '0;
      triple_mask_r <= '0;
      long_mask_r   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        REG_DEBOUNCE:    debounce_r    <= cfg_pwdata[7:0];
        REG_LONG_THRESH: long_thresh_r <= cfg_pwdata[15:0];
        REG_MULTI_WIN:   multi_win_r   <= cfg_pwdata[15:0];
        REG_HOLD_MASK:   hold_mask_r   <= cfg_pwdata[15:0];
        REG_DOUBLE_MASK: double_mask_r <= cfg_pwdata[15:0];
        REG_TRIPLE_MASK: triple_mask_r <= cfg_pwdata[15:0];
        REG_LONG_MASK:   long_mask_r   <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:2])
      REG_DEBOUNCE:    cfg_prdata = {24'd0, debounce_r};
      REG_LONG_THRESH: cfg_prdata = {16'd0, long_thresh_r};
      REG_MULTI_WIN:   cfg_prdata = {16'd0, multi_win_r};
      REG_HOLD_MASK:   cfg_prdata = {16'd0, hold_mask_r};
      REG_DOUBLE_MASK: cfg_prdata = {16'd0, double_mask_r};
      REG_TRIPLE_MASK: cfg_prdata = {16'd0, triple_mask_r};
      REG_LONG_MASK:   cfg_prdata = {16'd0, long_mask_r};
      default:         cfg_prdata = '0;
    endcase
  end

  // handshakes
  assign out_acc   = out_tvalid && out_tready;
  assign b_fire    = b_vld_r && ((rem_r == 3'd0) || ((rem_r == 3'd1) && out_tready));
  assign in_tready = !b_vld_r || b_fire;
  assign in_acc    = in_tvalid && in_tready;

  // request register, state read issued at accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (in_acc) begin
      b_vld_r <= 1'b1;
    end else if (b_fire) begin
      b_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_action_r <= in_tuser;
      b_button_r <= in_tdata[3:0];
      b_level_r  <= in_tdata[4];
      b_now_r    <= in_tdata[36:5];
    end
  end

  assign mem_req.rd_en   = in_acc;
  assign mem_req.rd_addr = in_tdata[3:0];
  assign mem_req.wr_en   = b_fire;
  assign mem_req.wr_addr = b_button_r;

  bdc_state_mem u_state_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mem_req),
    .wr_data  (new_st),
    .rd_entry (old_st)
  );

  assign d_press = b_now_r - old_st.press_time;
  assign d_rel   = b_now_r - old_st.release_time;
  assign mwin    = {16'd0, multi_win_r};
  assign lthr    = {16'd0, long_thresh_r};
  assign dbl     = double_mask_r[b_button_r];
  assign tpl     = triple_mask_r[b_button_r];
  assign hold    = hold_mask_r[b_button_r];
  assign lmask   = long_mask_r[b_button_r];

  // classification of one request
  always_comb begin
    new_st = old_st;
    ev_n   = 3'd0;
    for (int i = 0; i < MAX_EVENTS; i++) begin
      ev[i] = EV_PRESSED;
    end
    if ({1'b0, b_button_r} < (BTN_W + 1)'(BUTTONS)) begin
      if (b_action_r == ACT_SAMPLE) begin
        if (old_st.bounce_level != b_level_r) begin
          new_st.bounce_level   = b_level_r;
          new_st.bounce_counter = '0;
        end else if (old_st.bounce_counter < debounce_r) begin
          new_st.bounce_counter = old_st.bounce_counter + 8'd1;
          if ((new_st.bounce_counter == debounce_r) &&
              (b_level_r != old_st.stable_level)) begin
            new_st.stable_level = b_level_r;
            if (b_level_r) begin
              ev[ev_n[1:0]] = EV_PRESSED;
              ev_n = ev_n + 3'd1;
              new_st.long_fired = 1'b0;
              new_st.press_time = b_now_r;
              if ((multi_win_r != '0) && (dbl || tpl)) begin
                if (old_st.multi_pending && (d_rel <= mwin)) begin
                  if (old_st.press_count < 2'(MAX_PRESSES)) begin
                    new_st.press_count = old_st.press_count + 2'd1;
                  end
                end else begin
                  new_st.press_count = 2'd1;
                end
                new_st.multi_pending = 1'b1;
                if ((new_st.press_count == 2'(MAX_PRESSES)) && tpl) begin
                  ev[ev_n[1:0]] = EV_RELHOLD;
                  ev_n = ev_n + 3'd1;
                  ev[ev_n[1:0]] = EV_TRIPLE;
                  ev_n = ev_n + 3'd1;
                  new_st.press_count   = 2'd0;
                  new_st.multi_pending = 1'b0;
                end else if ((new_st.press_count >= 2'd2) && dbl && !tpl) begin
                  ev[ev_n[1:0]] = EV_RELHOLD;
                  ev_n = ev_n + 3'd1;
                  ev[ev_n[1:0]] = EV_DOUBLE;
                  ev_n = ev_n + 3'd1;
                  new_st.press_count   = 2'd0;
                  new_st.multi_pending = 1'b0;
                end
              end else begin
                ev[ev_n[1:0]] = EV_NORMAL;
                ev_n = ev_n + 3'd1;
              end
            end else begin
              ev[ev_n[1:0]] = EV_RELEASED;
              ev_n = ev_n + 3'd1;
              new_st.release_time = b_now_r;
            end
          end
        end else if (old_st.stable_level && (long_thresh_r != '0) &&
                     !old_st.long_fired && (d_press >= lthr)) begin
          new_st.long_fired = 1'b1;
          if (lmask) begin
            ev[ev_n[1:0]] = EV_LONG;
            ev_n = ev_n + 3'd1;
          end
        end
      end else begin
        if ((long_thresh_r != '0) && old_st.stable_level && !old_st.long_fired &&
            (d_press >= lthr)) begin
          new_st.long_fired = 1'b1;
          if (lmask) begin
            new_st.press_count   = 2'd0;
            new_st.multi_pending = 1'b0;
            ev[ev_n[1:0]] = EV_RELHOLD;
            ev_n = ev_n + 3'd1;
            ev[ev_n[1:0]] = EV_LONG;
            ev_n = ev_n + 3'd1;
          end
        end
        if ((multi_win_r != '0) && new_st.multi_pending) begin
          if (new_st.stable_level) begin
            if ((new_st.press_count == 2'd1) && hold && (d_press > mwin)) begin
              ev[ev_n[1:0]] = EV_NORMAL;
              ev_n = ev_n + 3'd1;
              new_st.press_count   = 2'd0;
              new_st.multi_pending = 1'b0;
            end
          end else if ((new_st.release_time != '0) && (d_rel > mwin)) begin
            if ((new_st.press_count == 2'(MAX_PRESSES)) && tpl) begin
              ev[ev_n[1:0]] = EV_RELHOLD;
              ev_n = ev_n + 3'd1;
              ev[ev_n[1:0]] = EV_TRIPLE;
              ev_n = ev_n + 3'd1;
            end else if ((new_st.press_count >= 2'd2) && dbl) begin
              ev[ev_n[1:0]] = EV_RELHOLD;
              ev_n = ev_n + 3'd1;
              ev[ev_n[1:0]] = EV_DOUBLE;
              ev_n = ev_n + 3'd1;
            end else if (new_st.press_count >= 2'd1) begin
              ev[ev_n[1:0]] = EV_NORMAL;
              ev_n = ev_n + 3'd1;
              if (hold) begin
                ev[ev_n[1:0]] = EV_RELHOLD;
                ev_n = ev_n + 3'd1;
              end
            end
            new_st.press_count   = 2'd0;
            new_st.multi_pending = 1'b0;
          end
        end
      end
    end
  end

  // event buffer, drained one per cycle while the output is ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      pos_r <= '0;
    end else if (b_fire) begin
      rem_r <= ev_n;
      pos_r <= '0;
    end else if (out_acc) begin
      rem_r <= rem_r - 3'd1;
      pos_r <= pos_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      ev_buf_r <= ev;
      ev_btn_r <= b_button_r;
    end
  end

  assign out_tvalid = (rem_r != 3'd0);
  assign out_tlast  = (rem_r == 3'd1);
  assign out_tdata  = {1'b0, ev_btn_r, ev_buf_r[pos_r]};

  // checks
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= 3'(MAX_EVENTS))
    else $error("event buffer count out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    b_fire |-> (rem_r == 3'd0) || (out_acc && out_tlast))
    else $error("event buffer loaded while events still pending");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (b_vld_r && !b_fire) |=> b_vld_r && $stable(b_button_r))
    else $error("stalled request lost");

  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> b_vld_r)
    else $error("accepted request not staged");

endmodule

FILE: src/bdc_state_mem.sv
// ----------------------------------------------------------------------------
// bdc_state_mem
// per-button state memory with registered read, valid bits and write forwarding
// ----------------------------------------------------------------------------
module bdc_state_mem (
  input  logic                clk,
  input  logic                rst_n,
  input  bdc_pkg::bdc_mem_req_t req,
  input  bdc_pkg::bdc_entry_t wr_data,
  output bdc_pkg::bdc_entry_t rd_entry
);
  import bdc_pkg::*;

  bdc_entry_t         mem [BUTTONS];
  bdc_entry_t         rd_data_r;
  bdc_entry_t         fwd_data_r;
  logic [BUTTONS-1:0] vld_r;
  logic               rd_vld_r;
  logic               fwd_hit_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_data_r  <= mem[req.rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      rd_vld_r  <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r  <= vld_r[req.rd_addr];
        fwd_hit_r <= req.wr_en && (req.wr_addr == req.rd_addr);
      end
    end
  end

  // same-entry write at the read edge wins, unwritten entries read as zero
  assign rd_entry = fwd_hit_r ? fwd_data_r : (rd_vld_r ? rd_data_r : '0);

endmodule

FILE: test/tb_button_debounce_click_classifier_unit.sv
// ----------------------------------------------------------------------------
// tb_button_debounce_click_classifier_unit
// self-checking testbench for the button debounce and click classifier
// ----------------------------------------------------------------------------
// Requests are sample and service items that arrive over the input stream in
// bursts with random gaps, while the event stream stalls on its own pattern.
// A scoreboard keeps its own copy of every button's debounce and click state
// and of the registers, predicts the events of each accepted request and
// compares every event, field by field, against the oldest prediction. The
// run starts from the reset settings, goes through directed press, release,
// long-press, multi-press and timestamp wrap cases, then through random click
// sequences under several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_button_debounce_click_classifier_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bdc_pkg::*;

  localparam int unsigned WATCHDOG_CYCLES = 300000;
  localparam int unsigned DRAIN_CYCLES    = 16;

  typedef struct packed {
    logic             act;
    logic [BTN_W-1:0] btn;
    logic             lvl;
    logic [31:0]      now;
  } request_t;

  typedef struct packed {
    bdc_event_t       code;
    logic [BTN_W-1:0] btn;
    logic             last;
  } click_event_t;

  class click_scoreboard;
    logic [7:0]  deb_cnt;
    logic [15:0] long_thr;
    logic [15:0] win;
    logic [15:0] hold_m;
    logic [15:0] dbl_m;
    logic [15:0] tpl_m;
    logic [15:0] long_m;

    logic        bnc_lvl    [BUTTONS];
    logic        stable     [BUTTONS];
    logic [7:0]  bnc_cnt    [BUTTONS];
    logic        long_fired [BUTTONS];
    logic [1:0]  press_cnt  [BUTTONS];
    logic        pend       [BUTTONS];
    logic [31:0] press_t    [BUTTONS];
    logic [31:0] release_t  [BUTTONS];

    click_event_t     expected_events[$];
    bdc_event_t       ev_codes[MAX_EVENTS];
    int               ev_n;
    logic [BTN_W-1:0] cur_btn;
    int unsigned      n_err;
    int unsigned      n_req;
    int unsigned      n_ev;

    function new();
      deb_cnt  = DEBOUNCE_RESET_COUNT;
      long_thr = '0;
      win      = '0;
      hold_m   = '0;
      dbl_m    = '0;
      tpl_m    = '0;
      long_m   = '0;
      for (int i = 0; i < BUTTONS; i++) begin
        bnc_lvl[i]    = 1'b0;
        stable[i]     = 1'b0;
        bnc_cnt[i]    = '0;
        long_fired[i] = 1'b0;
        press_cnt[i]  = '0;
        pend[i]       = 1'b0;
        press_t[i]    = '0;
        release_t[i]  = '0;
      end
      n_err = 0;
      n_req = 0;
      n_ev  = 0;
    endfunction

    function void set_reg(bdc_reg_t r, logic [31:0] v);
      case (r)
        REG_DEBOUNCE:    deb_cnt  = v[7:0];
        REG_LONG_THRESH: long_thr = v[15:0];
        REG_MULTI_WIN:   win      = v[15:0];
        REG_HOLD_MASK:   hold_m   = v[15:0];
        REG_DOUBLE_MASK: dbl_m    = v[15:0];
        REG_TRIPLE_MASK: tpl_m    = v[15:0];
        REG_LONG_MASK:   long_m   = v[15:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_events.size();
    endfunction

    function void add_event(bdc_event_t code);
      if (ev_n < MAX_EVENTS) begin
        ev_codes[ev_n] = code;
        ev_n++;
      end
    endfunction

    function void clear_multi(logic [BTN_W-1:0] b);
      press_cnt[b] = '0;
      pend[b]      = 1'b0;
    endfunction

    function void classify_press(logic [BTN_W-1:0] b, logic [31:0] now);
      logic [31:0] since_rel;
      since_rel     = now - release_t[b];
      long_fired[b] = 1'b0;
      press_t[b]    = now;
      if (win != 0 && (dbl_m[b] || tpl_m[b])) begin
        if (pend[b] && since_rel <= {16'h0, win}) begin
          if (press_cnt[b] < MAX_PRESSES) press_cnt[b]++;
        end else begin
          press_cnt[b] = 2'd1;
        end
        pend[b] = 1'b1;
        if (press_cnt[b] >= 3 && tpl_m[b]) begin
          add_event(EV_RELHOLD);
          add_event(EV_TRIPLE);
          clear_multi(b);
        end else if (press_cnt[b] >= 2 && dbl_m[b] && !tpl_m[b]) begin
          add_event(EV_RELHOLD);
          add_event(EV_DOUBLE);
          clear_multi(b);
        end
        return;
      end
      add_event(EV_NORMAL);
    endfunction

    function void debounce_sample(logic [BTN_W-1:0] b, logic lvl, logic [31:0] now);
      logic [31:0] since_press;
      since_press = now - press_t[b];
      if (bnc_lvl[b] != lvl) begin
        bnc_lvl[b] = lvl;
        bnc_cnt[b] = '0;
        return;
      end
      if (bnc_cnt[b] < deb_cnt) begin
        bnc_cnt[b]++;
        if (bnc_cnt[b] == deb_cnt && lvl != stable[b]) begin
          stable[b] = lvl;
          if (lvl) begin
            add_event(EV_PRESSED);
            classify_press(b, now);
          end else begin
            add_event(EV_RELEASED);
            release_t[b] = now;
          end
        end
      end else if (stable[b] && long_thr != 0 && !long_fired[b] &&
                   since_press >= {16'h0, long_thr}) begin
        long_fired[b] = 1'b1;
        if (long_m[b]) add_event(EV_LONG);
      end
    endfunction

    function void service_timeouts(logic [BTN_W-1:0] b, logic [31:0] now);
      logic [31:0] since_press;
      logic [31:0] since_rel;
      since_press = now - press_t[b];
      since_rel   = now - release_t[b];
      if (long_thr != 0 && stable[b] && !long_fired[b] &&
          since_press >= {16'h0, long_thr}) begin
        long_fired[b] = 1'b1;
        if (long_m[b]) begin
          clear_multi(b);
          add_event(EV_RELHOLD);
          add_event(EV_LONG);
        end
      end
      if (win == 0 || !pend[b]) return;
      if (stable[b]) begin
        if (press_cnt[b] == 1 && hold_m[b] && since_press > {16'h0, win}) begin
          add_event(EV_NORMAL);
          clear_multi(b);
        end
        return;
      end
      if (release_t[b] == 0) return;
      if (since_rel <= {16'h0, win}) return;
      if (press_cnt[b] >= 3 && tpl_m[b]) begin
        add_event(EV_RELHOLD);
        add_event(EV_TRIPLE);
      end else if (press_cnt[b] >= 2 && dbl_m[b]) begin
        add_event(EV_RELHOLD);
        add_event(EV_DOUBLE);
      end else if (press_cnt[b] >= 1) begin
        add_event(EV_NORMAL);
        if (hold_m[b]) add_event(EV_RELHOLD);
      end
      clear_multi(b);
    endfunction

    function void note_request(logic act, logic [BTN_W-1:0] b, logic lvl, logic [31:0] now);
      n_req++;
      ev_n    = 0;
      cur_btn = b;
      if (act == ACT_SAMPLE) debounce_sample(b, lvl, now);
      else service_timeouts(b, now);
      for (int i = 0; i < ev_n; i++) begin
        expected_events.push_back('{ev_codes[i], cur_btn, (i == ev_n - 1)});
      end
    endfunction

    function void check_event(logic [OUT_DATA_W-1:0] data, logic last);
      click_event_t e;
      n_ev++;
      if (expected_events.size() == 0) begin
        $error("unexpected event: event_res %0d event_button %0d last %0d",
               data[2:0], data[6:3], last);
        n_err++;
        return;
      end
      e = expected_events.pop_front();
      if (data[2:0] !== e.code) begin
        $error("event_res mismatch: expected %0d, got %0d", e.code, data[2:0]);
        n_err++;
      end
      if (data[6:3] !== e.btn) begin
        $error("event_button mismatch: expected %0d, got %0d", e.btn, data[6:3]);
        n_err++;
      end
      if (last !== e.last) begin
        $error("last mismatch: expected %0d, got %0d", e.last, last);
        n_err++;
      end
    endfunction
  endclass

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  // in_tdata: button[3:0], level[4], now_ms[36:5], zero fill
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  // in_tuser: action
  logic                  in_tuser    = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  // out_tdata: event_res[2:0], event_button[6:3], zero fill
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [31:0]           cfg_pwdata  = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  click_scoreboard sb;
  request_t        req_q[$];
  logic [31:0]     ms_now;
  int unsigned     n_settings = 0;

  button_debounce_click_classifier_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    repeat (WATCHDOG_CYCLES) @(posedge clk);
    $display("tb_button_debounce_click_classifier_unit: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_request(in_tuser, in_tdata[3:0], in_tdata[4], in_tdata[36:5]);
      if (out_tvalid && out_tready)
        sb.check_event(out_tdata, out_tlast);
    end
  end

  // event side stall pattern
  initial begin : event_throttle
    int unsigned mode;
    int unsigned span;
    logic        rdy;
    @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 48);
      for (int i = 0; i < span; i++) begin
        case (mode)
          0:       rdy = 1'b1;
          1:       rdy = i[0];
          2:       rdy = ($urandom_range(0, 3) != 0);
          default: rdy = ((i % 8) < 2);
        endcase
        out_tready <= rdy;
        @(posedge clk);
      end
    end
  end

  task automatic reg_write(bdc_reg_t r, logic [31:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {r, 2'b00};
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(r, v);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_setting(logic [31:0] deb, logic [31:0] lthr, logic [31:0] mwin,
                                 logic [31:0] hold, logic [31:0] dbl, logic [31:0] tpl,
                                 logic [31:0] lmask);
    reg_write(REG_DEBOUNCE, deb);
    reg_write(REG_LONG_THRESH, lthr);
    reg_write(REG_MULTI_WIN, mwin);
    reg_write(REG_HOLD_MASK, hold);
    reg_write(REG_DOUBLE_MASK, dbl);
    reg_write(REG_TRIPLE_MASK, tpl);
    reg_write(REG_LONG_MASK, lmask);
    n_settings++;
  endtask

  task automatic play_requests();
    request_t    rq;
    int unsigned burst;
    int unsigned gap;
    int unsigned total;
    int unsigned sent;
    bit          hold_off;
    bit          paused;
    total  = req_q.size();
    sent   = 0;
    paused = 1'b0;
    while (req_q.size() != 0) begin
      burst = $urandom_range(1, 10);
      while (burst != 0 && req_q.size() != 0) begin
        rq = req_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= rq.act;
        in_tdata  <= {3'b000, rq.now, rq.lvl, rq.btn};
        do @(posedge clk); while (!in_tready);
        burst--;
        sent++;
      end
      hold_off = (!paused && 2 * sent >= total) || ($urandom_range(0, 39) == 0);
      gap      = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (req_q.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (hold_off) begin
        // let every predicted event drain before the next request
        paused = 1'b1;
        in_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end else if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_events_drained();
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void add_sample(logic [3:0] b, logic lvl, int unsigned adv);
    ms_now += adv;
    req_q.push_back('{ACT_SAMPLE, b, lvl, ms_now});
  endfunction

  function automatic void add_service(logic [3:0] b, int unsigned adv);
    ms_now += adv;
    req_q.push_back('{ACT_SERVICE, b, 1'($urandom_range(0, 1)), ms_now});
  endfunction

  function automatic void add_level(logic [3:0] b, logic lvl, int unsigned n);
    for (int unsigned i = 0; i < n; i++) add_sample(b, lvl, $urandom_range(0, 2));
  endfunction

  function automatic void add_click(logic [3:0] b, int unsigned hold_ms);
    int unsigned n;
    n = sb.deb_cnt + 1;
    if ($urandom_range(0, 3) == 0) begin
      // contact chatter ahead of the press
      add_sample(b, 1'b1, 1);
      add_sample(b, 1'b0, 1);
    end
    add_level(b, 1'b1, n);
    ms_now += hold_ms;
    if ($urandom_range(0, 1) != 0) add_sample(b, 1'b1, 0);
    else add_service(b, 0);
    add_level(b, 1'b0, n);
  endfunction

  function automatic void gen_random_phase(int unsigned budget);
    logic [3:0]  b;
    int unsigned pick;
    int unsigned k;
    int unsigned n;
    while (req_q.size() < budget) begin
      b    = $urandom_range(0, 15);
      pick = $urandom_range(0, 19);
      n    = sb.deb_cnt + 1;
      if (pick < 8) begin
        add_click(b, ($urandom_range(0, 1) != 0) ? $urandom_range(0, sb.long_thr / 2)
                                                 : sb.long_thr + $urandom_range(0, 30));
        ms_now += sb.win + $urandom_range(1, 30);
        add_service(b, 0);
      end else if (pick < 13) begin
        k = $urandom_range(2, 4);
        for (int unsigned i = 0; i < k; i++) begin
          add_click(b, $urandom_range(0, sb.long_thr / 2 + 3));
          if (i + 1 < k) ms_now += $urandom_range(0, sb.win + 5);
        end
        ms_now += sb.win + $urandom_range(1, 20);
        add_service(b, 0);
      end else if (pick < 15) begin
        add_level(b, 1'b1, n);
        ms_now += sb.long_thr + $urandom_range(0, 20);
        add_service(b, 0);
        add_sample(b, 1'b1, 1);
        if ($urandom_range(0, 1) != 0) add_service(b, sb.win + 1);
        add_level(b, 1'b0, n);
        ms_now += sb.win + $urandom_range(1, 20);
        add_service(b, 0);
      end else if (pick < 18) begin
        if ($urandom_range(0, 1) != 0) add_sample(b, 1'($urandom_range(0, 1)),
                                                  $urandom_range(0, 50));
        else add_service(b, $urandom_range(0, 50));
      end else begin
        ms_now = ($urandom_range(0, 1) != 0) ? $urandom : 32'hFFFF_FF00 + $urandom_range(0, 200);
      end
    end
  endfunction

  initial begin : main_seq
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: plain press on the top button across the timestamp wrap
    ms_now = 32'hFFFF_FFFA;
    add_level(4'd15, 1'b1, 6);
    play_requests();
    wait_events_drained();

    program_setting(1, 50, 100, 32'h0002, 32'h0002, 32'h0002, 32'h800A);
    // release at time zero leaves the sequence unresolved
    ms_now = 32'hFFFF_FFF0;
    add_sample(4'd1, 1'b1, 0);
    add_sample(4'd1, 1'b1, 0);
    ms_now = 32'd0;
    add_sample(4'd1, 1'b0, 0);
    add_sample(4'd1, 1'b0, 0);
    ms_now = 32'd500;
    add_service(4'd1, 0);
    // long press seen while sampling keeps the pending sequence
    ms_now = 32'd510;
    add_level(4'd1, 1'b1, 2);
    ms_now = 32'd600;
    add_sample(4'd1, 1'b1, 0);
    ms_now = 32'd610;
    add_level(4'd1, 1'b0, 2);
    // triple press inside the window
    ms_now = 32'd620;
    add_level(4'd1, 1'b1, 2);
    ms_now = 32'd630;
    add_level(4'd1, 1'b0, 2);
    ms_now = 32'd640;
    add_level(4'd1, 1'b1, 2);
    ms_now = 32'd650;
    add_level(4'd1, 1'b0, 2);
    // long press found by a service pass
    ms_now = 32'd700;
    add_level(4'd3, 1'b1, 2);
    ms_now = 32'd760;
    add_service(4'd3, 0);
    ms_now = 32'd770;
    add_level(4'd3, 1'b0, 2);
    // single hold-style press resolved after the window
    ms_now = 32'd800;
    add_level(4'd1, 1'b1, 2);
    ms_now = 32'd810;
    add_level(4'd1, 1'b0, 2);
    ms_now = 32'd1000;
    add_service(4'd1, 0);
    play_requests();
    wait_events_drained();

    // zero debounce count: only the inline long check of a held button
    program_setting(0, 50, 0, 0, 0, 0, 32'h8000);
    ms_now = 32'd2000;
    add_sample(4'd15, 1'b1, 0);
    add_sample(4'd15, 1'b0, 1);
    add_sample(4'd15, 1'b0, 1);
    play_requests();
    wait_events_drained();

    program_setting(1, 40, 60, $urandom, $urandom, $urandom, $urandom);
    gen_random_phase(10);
    play_requests();
    wait_events_drained();

    program_setting(3, 0, 30, 32'hFFFF, 32'hFFFF, 32'h0000, 32'hFFFF);
    gen_random_phase(8);
    play_requests();
    wait_events_drained();

    program_setting(2, 65535, 65535, $urandom, $urandom, $urandom, $urandom);
    gen_random_phase(8);
    play_requests();
    wait_events_drained();

    // widest debounce count: a short steady run never settles
    program_setting(255, 500, 0, $urandom, 0, 0, 32'hFFFF);
    add_level(4'd5, 1'b1, 12);
    add_service(4'd5, 600);
    add_level(4'd5, 1'b0, 4);
    play_requests();
    wait_events_drained();

    program_setting(1, 20, 50, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF);
    gen_random_phase(10);
    play_requests();
    wait_events_drained();

    $display("checked %0d requests and %0d events under %0d register settings,",
             sb.n_req, sb.n_ev, n_settings);
    $display("covering debounce extremes, long and multi-press timeouts and time wrap");
    if (sb.n_err == 0 && sb.pending() == 0) begin
      $display("tb_button_debounce_click_classifier_unit: clean");
    end else begin
      $display("tb_button_debounce_click_classifier_unit: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/bdc_pkg.sv
src/bdc_state_mem.sv
src/button_debounce_click_classifier_unit.sv
test/tb_button_debounce_click_classifier_unit.sv
